FILE: rtl/core/rc4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, opcodes and status codes for the RC4 byte cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Permutation table: fixed at 256 byte entries.
  localparam int TBL_SIZE = 256;
  localparam int TBL_AW   = 8;
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TBL_SIZE - 1);

  localparam int BYTE_W = 8;

  // Default key store depth.
  localparam int DEF_MAX_KEY_BYTES = 256;

  typedef enum logic [1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CRYPT    = 2'd2
  } rc4_op_t;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_KEY = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/rc4_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/rc4_stream_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte-wide RC4: key loading, key schedule and keystream XOR on one
// permutation RAM driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Each input transaction carries an opcode and a byte and gives exactly one
// result transaction. Opcode 0 appends a key byte (status 1 once the key
// store already holds MAX_KEY_BYTES), opcode 1 runs the key schedule over the
// stored key and empties it (status 1 on an empty key), opcode 2 XORs the
// byte with the next keystream byte; opcode 3 does nothing. data_out is zero
// except for opcode 2. After reset the permutation RAM is filled with the
// identity while in_ready stays low. Key byte loads, failed requests and
// opcode 3 complete in the idle state that accepts them. A data byte runs in
// steps set by the single read and single write port of the permutation RAM:
// read S[i], read S[j], write S[i] while reading the keystream entry, write
// S[j]. The key schedule fills the same RAM with the identity, then runs 256
// swap steps through S_K_RD, S_K_RDJ, S_K_WR_A, S_K_WR_B. Only one transaction
// is in flight. A finished result goes straight into the output register when
// that is free or drains in the same cycle, and the block returns to idle;
// otherwise it is parked in a one-entry holding register and in_ready stays
// low until out_ready frees the output register.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [rc4_pkg::BYTE_W-1:0] in_data_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rc4_pkg::BYTE_W-1:0] out_data_out,
  output logic                       out_status
);

  import rc4_pkg::*;

  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_LW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KEY_LW-1:0] KEY_MAX = KEY_LW'(MAX_KEY_BYTES);

  typedef enum logic [3:0] {
    S_FILL_RST,  // identity fill after reset
    S_IDLE,
    S_FILL_KS,   // identity fill at start of key schedule
    S_K_RD,      // issue read of S[n] and key byte
    S_K_RDJ,     // compute j, issue read of S[j]
    S_K_WR_A,    // S[n] <= S[j]
    S_K_WR_B,    // S[j] <= S[n]
    S_P_RDJ,     // got S[i], compute j, issue read of S[j]
    S_P_WR_I,    // S[i] <= S[j], issue keystream read
    S_P_WR_J,    // S[j] <= S[i], form result
    S_RESP       // result parked until the output register frees
  } state_t;

  state_t              state_r, state_nxt;
  logic [TBL_AW-1:0]   cnt_r, cnt_nxt;       // fill address / schedule step
  logic [KEY_AW-1:0]   kpos_r, kpos_nxt;
  logic [KEY_LW-1:0]   key_len_r, key_len_nxt;
  logic [TBL_AW-1:0]   idx_i_r, idx_i_nxt;
  logic [TBL_AW-1:0]   idx_j_r, idx_j_nxt;
  logic [BYTE_W-1:0]   sa_r, sa_nxt;         // S[n] or S[i] before the swap
  logic [BYTE_W-1:0]   sj_r, sj_nxt;         // S[j] before the swap
  logic [TBL_AW-1:0]   t_r, t_nxt;           // keystream index
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [BYTE_W-1:0]   res_dout_r, res_dout_nxt;
  logic                res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_dout_r, out_dout_nxt;
  logic                out_st_r, out_st_nxt;

  // RAM ports
  logic                perm_we;
  logic [TBL_AW-1:0]   perm_waddr;
  logic [BYTE_W-1:0]   perm_wdata;
  logic [TBL_AW-1:0]   perm_raddr;
  logic [BYTE_W-1:0]   perm_rdata;
  logic                key_we;
  logic [KEY_AW-1:0]   key_waddr;
  logic [KEY_AW-1:0]   key_raddr;
  logic [BYTE_W-1:0]   key_rdata;

  // Finish request and helpers
  logic                fin;
  logic [BYTE_W-1:0]   fin_dout;
  logic                fin_st;
  logic                out_free;
  logic [KEY_LW-1:0]   kpos_inc;
  logic [BYTE_W-1:0]   ks_byte;

  rc4_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (TBL_SIZE),
    .ADDR_W (TBL_AW)
  ) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  rc4_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (MAX_KEY_BYTES),
    .ADDR_W (KEY_AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_data_in),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_data_out = out_dout_r;
  assign out_status   = out_st_r;

  assign out_free = !out_valid_r || out_ready;
  assign kpos_inc = KEY_LW'(kpos_r) + KEY_LW'(1);

  // Keystream entry was read while S[i] was being written: forward the
  // swapped values when the index hits either swapped slot.
  always_comb begin
    if (t_r == idx_j_r) begin
      ks_byte = sa_r;
    end else if (t_r == idx_i_r) begin
      ks_byte = sj_r;
    end else begin
      ks_byte = perm_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kpos_nxt      = kpos_r;
    key_len_nxt   = key_len_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    sa_nxt        = sa_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    data_nxt      = data_r;
    res_dout_nxt  = res_dout_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dout_nxt  = out_dout_r;
    out_st_nxt    = out_st_r;

    fin        = 1'b0;
    fin_dout   = '0;
    fin_st     = ST_OK;
    perm_we    = 1'b0;
    perm_waddr = cnt_r;
    perm_wdata = cnt_r;
    perm_raddr = cnt_r;
    key_we     = 1'b0;
    key_waddr  = key_len_r[KEY_AW-1:0];
    key_raddr  = kpos_r;

    unique case (state_r) inside
      S_FILL_RST, S_FILL_KS: begin
        perm_we = 1'b1;
        cnt_nxt = cnt_r + TBL_AW'(1);
        if (cnt_r == TBL_LAST) begin
          state_nxt = (state_r == S_FILL_RST) ? S_IDLE : S_K_RD;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD_KEY: begin
              fin = 1'b1;
              if (key_len_r < KEY_MAX) begin
                key_we      = 1'b1;
                key_len_nxt = key_len_r + KEY_LW'(1);
              end else begin
                fin_st = ST_BAD_KEY;
              end
            end
            OP_SCHEDULE: begin
              if (key_len_r == '0) begin
                fin    = 1'b1;
                fin_st = ST_BAD_KEY;
              end else begin
                cnt_nxt   = '0;
                kpos_nxt  = '0;
                idx_j_nxt = '0;
                state_nxt = S_FILL_KS;
              end
            end
            OP_CRYPT: begin
              perm_raddr = idx_i_r + TBL_AW'(1);
              idx_i_nxt  = idx_i_r + TBL_AW'(1);
              data_nxt   = in_data_in;
              state_nxt  = S_P_RDJ;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_K_RD: begin
        state_nxt = S_K_RDJ;
      end

      S_K_RDJ: begin
        perm_raddr = idx_j_r + key_rdata + perm_rdata;
        idx_j_nxt  = idx_j_r + key_rdata + perm_rdata;
        sa_nxt     = perm_rdata;
        state_nxt  = S_K_WR_A;
      end

      S_K_WR_A: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata;
        state_nxt  = S_K_WR_B;
      end

      S_K_WR_B: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j_r;
        perm_wdata = sa_r;
        cnt_nxt    = cnt_r + TBL_AW'(1);
        kpos_nxt   = (kpos_inc >= key_len_r) ? '0 : kpos_inc[KEY_AW-1:0];
        if (cnt_r == TBL_LAST) begin
          idx_i_nxt   = '0;
          idx_j_nxt   = '0;
          key_len_nxt = '0;
          fin         = 1'b1;
        end else begin
          state_nxt = S_K_RD;
        end
      end

      S_P_RDJ: begin
        perm_raddr = idx_j_r + perm_rdata;
        idx_j_nxt  = idx_j_r + perm_rdata;
        sa_nxt     = perm_rdata;
        state_nxt  = S_P_WR_I;
      end

      S_P_WR_I: begin
        perm_we    = 1'b1;
        perm_waddr = idx_i_r;
        perm_wdata = perm_rdata;
        perm_raddr = sa_r + perm_rdata;
        t_nxt      = sa_r + perm_rdata;
        sj_nxt     = perm_rdata;
        state_nxt  = S_P_WR_J;
      end

      S_P_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j_r;
        perm_wdata = sa_r;
        fin        = 1'b1;
        fin_dout   = data_r ^ ks_byte;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dout_nxt  = res_dout_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Deliver the result now if the output register is free, else park it.
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_dout_nxt  = fin_dout;
        out_st_nxt    = fin_st;
        state_nxt     = S_IDLE;
      end else begin
        res_dout_nxt = fin_dout;
        res_st_nxt   = fin_st;
        state_nxt    = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL_RST;
      cnt_r       <= '0;
      kpos_r      <= '0;
      key_len_r   <= '0;
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      sa_r        <= '0;
      sj_r        <= '0;
      t_r         <= '0;
      data_r      <= '0;
      res_dout_r  <= '0;
      res_st_r    <= ST_OK;
      out_valid_r <= 1'b0;
      out_dout_r  <= '0;
      out_st_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      kpos_r      <= kpos_nxt;
      key_len_r   <= key_len_nxt;
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      sa_r        <= sa_nxt;
      sj_r        <= sj_nxt;
      t_r         <= t_nxt;
      data_r      <= data_nxt;
      res_dout_r  <= res_dout_nxt;
      res_st_r    <= res_st_nxt;
      out_valid_r <= out_valid_nxt;
      out_dout_r  <= out_dout_nxt;
      out_st_r    <= out_st_nxt;
    end
  end

`ifndef SYNTHESIS
  // Last swap of the schedule leaves both indices and the key store cleared.
  a_ks_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_WR_B && cnt_r == TBL_LAST) |=>
      (key_len_r == '0 && idx_i_r == '0 && idx_j_r == '0))
    else $error("key schedule did not clear indices or key length");

  // An accepted key byte with room left grows the key by exactly one.
  a_key_append: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_LOAD_KEY && key_len_r < KEY_MAX) |=>
      (key_len_r == $past(key_len_r) + KEY_LW'(1)))
    else $error("key byte not appended");

  // A result only appears from a state that completes a transaction.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(state_r == S_IDLE || state_r == S_K_WR_B ||
            state_r == S_P_WR_J || state_r == S_RESP))
    else $error("result raised outside a completing state");
`endif

endmodule
`default_nettype wire
